@@ rtl/rdtw_pkg.sv @@
// Package for the robust data-term weight block: field widths and reset values.
// No dependencies; imported by robust_data_term_weight.
package rdtw_pkg;

  // Width of the weight result, fixed by the output field.
  localparam int WEIGHT_W = 28;

  // Default number of fractional bits of the weight.
  localparam int WEIGHT_FRAC_BITS_DEF = 24;

  // Width of the exact energy with 48 fractional bits; its magnitude stays below 2^80.
  localparam int SUM_W = 82;

  // Reset value of epsilon, about 0.001 in Q16.16.
  localparam logic [15:0] EPS_RESET = 16'd66;

endpackage

@@ rtl/robust_data_term_weight.sv @@
// Robust data-term weight: quadratic tensor energy followed by 1/(2*sqrt(x+epsilon)).
// Depends on rdtw_pkg for widths and the epsilon reset value.
//
//  channel | handshake                | payload
//  --------+--------------------------+----------------------------------------
//  in      | in_valid_i / in_ready_o  | j11_i j22_i j33_i j12_i j13_i j23_i du_i dv_i
//  out     | out_valid_o / out_ready_i| weight_o
//  cfg     | cfg_valid_i / cfg_ready_o| cfg_epsilon_i
//
// One beat enters per cycle and one result leaves per cycle once the pipeline is full
// and the output is not stalled. Five stages form the energy with split 32x24
// multipliers and adder stages, then one stage per weight bit decides that bit of the
// reciprocal root with a single wide subtract and sign test.
// Each stage holds a valid bit and moves on when the stage after it is empty or moving,
// so a stalled output only holds back stages that are full and bubbles close up.
// Reset clears the valid bits and sets epsilon to its default; data registers are not reset.
module robust_data_term_weight
  import rdtw_pkg::*;
#(
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  j11_i,
  input  logic signed [31:0]  j22_i,
  input  logic signed [31:0]  j33_i,
  input  logic signed [31:0]  j12_i,
  input  logic signed [31:0]  j13_i,
  input  logic signed [31:0]  j23_i,
  input  logic signed [23:0]  du_i,
  input  logic signed [23:0]  dv_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [WEIGHT_W-1:0] weight_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_epsilon_i
);

  // Front stages before the root stages.
  localparam int NFRONT = 5;
  localparam int NST    = NFRONT + WEIGHT_W;
  // Remainder width: the subtrahend stays below 2^(2W+35), the target is 2^(2F+16).
  localparam int RW_A   = 2 * WEIGHT_W + 36;
  localparam int RW_B   = 2 * WEIGHT_FRAC_BITS + 18;
  localparam int RW     = (RW_A > RW_B) ? RW_A : RW_B;
  // Running product m*s with |m| below 2^(W+1) and s below 2^32.
  localparam int MW     = WEIGHT_W + 34;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [RW-1:0]    rem_t;
  typedef logic signed [MW-1:0]    prod_t;

  logic [NST-1:0] vld_q;
  logic [NST-1:0] vld_in;
  logic [NST-1:0] en;
  logic [15:0]    eps_q;

  // Stage A: squares, cross product and linear products.
  logic signed [47:0] squ_a_q, sqv_a_q, duv_a_q;
  logic signed [55:0] t13_a_q, t23_a_q;
  logic signed [31:0] j11_a_q, j22_a_q, j33_a_q, j12_a_q;
  // Stage B: partial products against the tensor entries.
  logic signed [56:0] m11lo_b_q, m11hi_b_q, m22lo_b_q, m22hi_b_q, m12lo_b_q, m12hi_b_q;
  logic signed [55:0] t13_b_q, t23_b_q;
  logic signed [31:0] j33_b_q;
  // Stage C: recombined terms.
  sum_t p11_c_q, p22_c_q, p12_c_q, lin_c_q;
  // Stage D: two partial sums.
  sum_t s1_d_q, s2_d_q;
  // Stage E: clamped energy in Q16.16.
  sum_t        sum_e;
  logic [30:0] x_e_d, x_e_q;
  logic [31:0] s_init;

  // Root stages.
  logic [WEIGHT_W-1:0] rw_q [WEIGHT_W];
  rem_t                rr_q [WEIGHT_W];
  prod_t               rm_q [WEIGHT_W];
  logic [31:0]         rs_q [WEIGHT_W];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
    end else if (cfg_valid_i) begin
      eps_q <= cfg_epsilon_i;
    end
  end

  // A stage may load when it is empty or when its successor loads.
  assign en[NST-1] = ~vld_q[NST-1] | out_ready_i;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = ~vld_q[k] | en[k+1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NST-1];
  assign weight_o    = rw_q[WEIGHT_W-1];

  // Valid bit that each stage would take from its predecessor.
  assign vld_in = {vld_q[NST-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      squ_a_q <= du_i * du_i;
      sqv_a_q <= dv_i * dv_i;
      duv_a_q <= du_i * dv_i;
      t13_a_q <= j13_i * du_i;
      t23_a_q <= j23_i * dv_i;
      j11_a_q <= j11_i;
      j22_a_q <= j22_i;
      j33_a_q <= j33_i;
      j12_a_q <= j12_i;
    end
  end

  // The squares are non-negative, so both halves are taken as unsigned.
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      m11lo_b_q <= j11_a_q * $signed({1'b0, squ_a_q[23:0]});
      m11hi_b_q <= j11_a_q * $signed({1'b0, squ_a_q[47:24]});
      m22lo_b_q <= j22_a_q * $signed({1'b0, sqv_a_q[23:0]});
      m22hi_b_q <= j22_a_q * $signed({1'b0, sqv_a_q[47:24]});
      m12lo_b_q <= j12_a_q * $signed({1'b0, duv_a_q[23:0]});
      m12hi_b_q <= j12_a_q * $signed(duv_a_q[47:24]);
      t13_b_q   <= t13_a_q;
      t23_b_q   <= t23_a_q;
      j33_b_q   <= j33_a_q;
    end
  end

  // Every term is brought to 48 fractional bits.
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      p11_c_q <= (sum_t'(m11hi_b_q) <<< 24) + sum_t'(m11lo_b_q);
      p22_c_q <= (sum_t'(m22hi_b_q) <<< 24) + sum_t'(m22lo_b_q);
      p12_c_q <= ((sum_t'(m12hi_b_q) <<< 24) + sum_t'(m12lo_b_q)) <<< 1;
      lin_c_q <= (sum_t'(t13_b_q) <<< 17) + (sum_t'(t23_b_q) <<< 17)
               + (sum_t'(j33_b_q) <<< 32);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s1_d_q <= p11_c_q + p22_c_q;
      s2_d_q <= p12_c_q + lin_c_q;
    end
  end

  // Negative energy becomes zero; anything from 2^63 upward saturates.
  always_comb begin
    sum_e = s1_d_q + s2_d_q;
    if (sum_e[SUM_W-1]) begin
      x_e_d = '0;
    end else if (|sum_e[SUM_W-2:63]) begin
      x_e_d = '1;
    end else begin
      x_e_d = sum_e[62:32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      x_e_q <= x_e_d;
    end
  end

  assign s_init = {1'b0, x_e_q} + {16'd0, eps_q};

  // Bit by bit, the largest w with (2w-1)^2 * s <= 2^(2F+16) is kept. The remainder
  // r = 2^(2F+16) - m^2*s and the product m*s are updated incrementally, with m = 2w-1.
  for (genvar i = 0; i < WEIGHT_W; i++) begin : g_root
    localparam int K = WEIGHT_W - 1 - i;
    logic [WEIGHT_W-1:0] pw;
    rem_t                pr;
    prod_t               pm;
    logic [31:0]         ps;
    rem_t                rn;
    logic                take;

    if (i == 0) begin : g_first
      assign pw = '0;
      assign pr = (rem_t'(1) <<< (2 * WEIGHT_FRAC_BITS + 16)) - rem_t'({1'b0, s_init});
      assign pm = prod_t'(0) - prod_t'({1'b0, s_init});
      assign ps = s_init;
    end else begin : g_next
      assign pw = rw_q[i-1];
      assign pr = rr_q[i-1];
      assign pm = rm_q[i-1];
      assign ps = rs_q[i-1];
    end

    assign rn   = pr - (rem_t'(pm) <<< (K + 2)) - (rem_t'({1'b0, ps}) <<< (2 * K + 2));
    assign take = ~rn[RW-1];

    always_ff @(posedge clk_i) begin
      if (en[NFRONT+i]) begin
        rs_q[i] <= ps;
        if (take) begin
          rw_q[i] <= pw | (WEIGHT_W'(1) << K);
          rr_q[i] <= rn;
          rm_q[i] <= pm + (prod_t'({1'b0, ps}) <<< (K + 1));
        end else begin
          rw_q[i] <= pw;
          rr_q[i] <= pr;
          rm_q[i] <= pm;
        end
      end
    end
  end

  // A blocked input means every stage holds a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_ready_o |-> (&vld_q))
    else $error("input stalled while a stage is empty");

  // An accepted beat lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted beat lost at the first stage");

  // A zero radicand saturates the weight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (rs_q[WEIGHT_W-1] == 32'd0) |-> (weight_o == {WEIGHT_W{1'b1}}))
    else $error("zero radicand did not saturate the weight");

endmodule

@@ tb/robust_data_term_weight_tb.sv @@
// Self-checking testbench for robust_data_term_weight: the tensor energy and weight checks.
// It needs only rdtw_pkg and the block. A scoreboard class predicts the weight of
// every accepted pixel, and plain tasks drive the pixel and epsilon channels.
module robust_data_term_weight_tb;
  import rdtw_pkg::*;

  // One pixel as it crosses the input channel.
  typedef struct packed {
    logic signed [31:0] j11;
    logic signed [31:0] j22;
    logic signed [31:0] j33;
    logic signed [31:0] j12;
    logic signed [31:0] j13;
    logic signed [31:0] j23;
    logic signed [23:0] du;
    logic signed [23:0] dv;
  } pixel_t;

  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          DRAIN_CYCLES   = 40;
  localparam logic [27:0] WEIGHT_SAT     = 28'hFFFFFFF;
  localparam logic [31:0] ENERGY_SAT     = 32'h7FFFFFFF;

  // The scoreboard keeps its own copy of epsilon and a queue of pending weights.
  class weight_scoreboard;
    logic [15:0] eps;
    logic [27:0] pending_weights[$];
    int          n_errors;

    function new();
      eps = EPS_RESET;
      n_errors = 0;
    endfunction

    // The clamped Q16.16 energy of one pixel, formed exactly with 48 fractional bits.
    function logic [31:0] clamped_energy(pixel_t px);
      logic signed [127:0] s11, s22, s33, s12, s13, s23, sdu, sdv, acc;
      s11 = px.j11; s22 = px.j22; s33 = px.j33;
      s12 = px.j12; s13 = px.j13; s23 = px.j23;
      sdu = px.du;  sdv = px.dv;
      acc = s11 * sdu * sdu + s22 * sdv * sdv + (s33 <<< 32)
          + 128'sd2 * s12 * sdu * sdv
          + s13 * sdu * 128'sd131072 + s23 * sdv * 128'sd131072;
      if (acc < 0) return '0;
      if (acc >= (128'sd1 <<< 63)) return ENERGY_SAT;
      return acc[63:32];
    endfunction

    // Largest weight w with (2w-1)^2 * root_arg <= 2^(2F+16), i.e. the rounded
    // reciprocal of twice the root, found by bisection over the weight range.
    function logic [27:0] weight_of(logic [32:0] root_arg);
      logic [127:0] lo, hi, mid, m, bound;
      bound = 128'd1 << (2 * WEIGHT_FRAC_BITS_DEF + 16);
      lo = 0;
      hi = WEIGHT_SAT;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        m = 2 * mid - 1;
        if (m * m * root_arg <= bound) lo = mid;
        else hi = mid - 1;
      end
      return lo[27:0];
    endfunction

    function void note_pixel(pixel_t px);
      logic [32:0] root_arg;
      root_arg = {1'b0, clamped_energy(px)} + eps;
      pending_weights.push_back(weight_of(root_arg));
    endfunction

    function void check_weight(logic [27:0] actual);
      logic [27:0] want;
      if (pending_weights.size() == 0) begin
        $error("weight beat 0x%07h arrived with no pixel outstanding", actual);
        n_errors++;
        return;
      end
      want = pending_weights.pop_front();
      if (actual !== want) begin
        $error("field weight: expected 0x%07h, actual 0x%07h", want, actual);
        n_errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o;
  pixel_t      px_q;
  logic        out_valid_o, out_ready_i;
  logic [27:0] weight_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [15:0] cfg_epsilon_i;

  weight_scoreboard sb;
  bit               long_hold_req;
  int               quiet_cycles;

  robust_data_term_weight u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .j11_i        (px_q.j11),
    .j22_i        (px_q.j22),
    .j33_i        (px_q.j33),
    .j12_i        (px_q.j12),
    .j13_i        (px_q.j13),
    .j23_i        (px_q.j23),
    .du_i         (px_q.du),
    .dv_i         (px_q.dv),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .weight_o     (weight_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_epsilon_i(cfg_epsilon_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offers one pixel and holds it until the block takes the beat. The caller is
  // always just past a rising edge, so valid is never dropped and raised in one step.
  task automatic send_pixel(pixel_t px);
    in_valid_i <= 1'b1;
    px_q       <= px;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_pixel(px);
  endtask

  task automatic idle_input(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Writes epsilon. Only called once the pipeline has emptied.
  task automatic write_epsilon(logic [15:0] value);
    cfg_valid_i   <= 1'b1;
    cfg_epsilon_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.eps = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending_weights.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_range32(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  // Random pixels come in three flavours. Most are plausible flow data whose
  // energy lands inside Q16.16, so the root and the rounding do real work; some are
  // raw bit patterns that mostly hit the clamps at either end, the rest tiny energies.
  function automatic pixel_t random_pixel();
    pixel_t px;
    int     flavour;
    flavour = $urandom_range(9);
    if (flavour < 2) begin
      px = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            24'($urandom), 24'($urandom)};
    end else if (flavour < 8) begin
      px.j11 = $urandom_range(32'h0004_0000);
      px.j22 = $urandom_range(32'h0004_0000);
      px.j12 = rand_range32(32'h0002_0000);
      px.j13 = rand_range32(32'h0004_0000);
      px.j23 = rand_range32(32'h0004_0000);
      px.j33 = $urandom_range(32'h0010_0000);
      px.du  = 24'(rand_range32(32'h0003_0000));
      px.dv  = 24'(rand_range32(32'h0003_0000));
    end else begin
      // Tiny energies, where the weight is largest and may saturate.
      px.j11 = $urandom_range(255);
      px.j22 = $urandom_range(255);
      px.j12 = rand_range32(64);
      px.j13 = rand_range32(64);
      px.j23 = rand_range32(64);
      px.j33 = rand_range32(32);
      px.du  = 24'(rand_range32(512));
      px.dv  = 24'(rand_range32(512));
    end
    return px;
  endfunction

  // The sender works in bursts: a random run of back-to-back beats, then mostly a gap.
  task automatic send_random_burst(int n_items);
    int burst;
    int sent;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < n_items; i++) begin
        send_pixel(random_pixel());
        sent++;
      end
      if ($urandom_range(3) != 0) idle_input($urandom_range(1, 12));
    end
  endtask

  task automatic send_directed();
    pixel_t px;
    // All zero: the energy is zero, so the weight rests on epsilon alone.
    px = '0;
    send_pixel(px);
    // Every field at its largest: the energy overflows and saturates.
    px = {{6{32'sh7FFFFFFF}}, 24'sh7FFFFF, 24'sh7FFFFF};
    send_pixel(px);
    // Every field at its smallest.
    px = {{6{32'sh80000000}}, 24'sh800000, 24'sh800000};
    send_pixel(px);
    // A strongly negative constant term drives the energy below zero.
    px = '0; px.j33 = 32'sh80000000;
    send_pixel(px);
    px = '0; px.j33 = -32'sd1;
    send_pixel(px);
    // The constant term alone at its largest sits just under the clamp.
    px = '0; px.j33 = 32'sh7FFFFFFF;
    send_pixel(px);
    // One unit of energy: the smallest non-zero root argument above epsilon.
    px = '0; px.j33 = 32'sd1;
    send_pixel(px);
    // Extreme flow increments under a unit tensor.
    px = '0; px.j11 = 32'sh0001_0000; px.j22 = 32'sh0001_0000;
    px.du = 24'sh800000; px.dv = 24'sh7FFFFF;
    send_pixel(px);
    // Cross term and linear terms on their own, with mixed signs.
    px = '0; px.j12 = 32'shFFFF_0000; px.du = 24'sh010000; px.dv = 24'sh020000;
    send_pixel(px);
    px = '0; px.j13 = 32'sh0000_8000; px.j23 = 32'shFFFF_C000;
    px.du = 24'shFE0000; px.dv = 24'sh030000;
    send_pixel(px);
    // Alternating bit patterns, so every input bit is seen at both values.
    px = {{6{32'sh5555AAAA}}, 24'shAA55AA, 24'sh55AA55};
    send_pixel(px);
    px = {{6{32'shAAAA5555}}, 24'sh55AA55, 24'shAA55AA};
    send_pixel(px);
    idle_input(1);
  endtask

  // Receiver: ready follows a changing stall pattern, and once, on request, it
  // holds off for a long stretch so that the pipeline fills and stalls its input.
  initial begin
    int window;
    int stall_pct;
    int hold;
    window = 0;
    stall_pct = 0;
    hold = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_weight(weight_o);
      if (long_hold_req && hold == 0) begin
        long_hold_req = 1'b0;
        hold = 200;
      end
      if (window == 0) begin
        window = $urandom_range(20, 120);
        case ($urandom_range(4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 30;
          3:       stall_pct = 70;
          default: stall_pct = 95;
        endcase
      end
      window--;
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: any stretch without a beat on any channel beyond the limit ends the run.
  initial begin
    quiet_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
          || (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] eps_plan[7];
    sb = new();
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    px_q          <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_epsilon_i <= '0;
    long_hold_req = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First phase runs on the reset epsilon, the later ones on written values,
    // the extremes among them and zero.
    eps_plan = '{16'd1, 16'd65535, 16'd0, 16'd66, 16'($urandom), 16'($urandom_range(1, 300))
                 , 16'($urandom)};
    send_directed();
    send_random_burst(150);
    foreach (eps_plan[p]) begin
      wait_drained();
      write_epsilon(eps_plan[p]);
      if (p == 0 || p == 2) send_directed();
      if (p == 3) begin
        // The long hold-off lands while the sender keeps pushing.
        long_hold_req = 1'b1;
        send_random_burst(300);
      end else begin
        send_random_burst(150);
      end
    end
    wait_drained();

    if (sb.n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rdtw_pkg.sv
rtl/robust_data_term_weight.sv
tb/robust_data_term_weight_tb.sv
